[design/traffic_light_controller_assert.svh]
// ----------------------------------------------------------------------------
// Traffic light controller assertion macros
// Concurrent checks clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH
`define TRAFFIC_LIGHT_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define TLC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define TLC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TLC_ASSERT_IMP(label, ante, cons, msg)
`define TLC_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

[design/tlc_pkg.sv]
// ----------------------------------------------------------------------------
// Traffic light controller package
// Shared widths, register and phase codes, lamp codes and display helpers.
// ----------------------------------------------------------------------------
package tlc_pkg;

  localparam int SEC_W   = 7;
  localparam int WARN_W  = 4;
  localparam int TICK_W  = 10;
  localparam int BLINK_W = 9;
  localparam int DEB_W   = 4;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [2:0] REG_NS_GREEN  = 3'd0;
  localparam logic [2:0] REG_EW_GREEN  = 3'd1;
  localparam logic [2:0] REG_WARN      = 3'd2;
  localparam logic [2:0] REG_TPS       = 3'd3;
  localparam logic [2:0] REG_BLINK     = 3'd4;
  localparam logic [2:0] REG_DEBOUNCE  = 3'd5;

  localparam logic [SEC_W-1:0]   RST_NS_GREEN = 7'd20;
  localparam logic [SEC_W-1:0]   RST_EW_GREEN = 7'd15;
  localparam logic [WARN_W-1:0]  RST_WARN     = 4'd3;
  localparam logic [TICK_W-1:0]  RST_TPS      = 10'd1000;
  localparam logic [BLINK_W-1:0] RST_BLINK    = 9'd500;
  localparam logic [DEB_W-1:0]   RST_DEBOUNCE = 4'd10;

  localparam logic [1:0] PH_NS_GO   = 2'd0;
  localparam logic [1:0] PH_NS_WARN = 2'd1;
  localparam logic [1:0] PH_EW_GO   = 2'd2;
  localparam logic [1:0] PH_EW_WARN = 2'd3;

  localparam logic [2:0] LAMP_OFF = 3'b000;
  localparam logic [2:0] LAMP_GRN = 3'b001;
  localparam logic [2:0] LAMP_YEL = 3'b010;
  localparam logic [2:0] LAMP_RED = 3'b100;

  localparam logic [7:0] SEG_BLANK = 8'hFF;
  localparam logic [6:0] SHOW_MAX  = 7'd99;

  typedef struct packed {
    logic emergency;
    logic leave;
  } key_view_t;

  typedef struct packed {
    logic [1:0]       phase;
    logic [SEC_W-1:0] seconds;
    logic             blink_on;
    logic             sec_evt;
  } seq_view_t;

  function automatic logic [7:0] seg_lookup(logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0: s = 8'hC0;
      4'd1: s = 8'hF9;
      4'd2: s = 8'hA4;
      4'd3: s = 8'hB0;
      4'd4: s = 8'h99;
      4'd5: s = 8'h92;
      4'd6: s = 8'h82;
      4'd7: s = 8'hF8;
      4'd8: s = 8'h80;
      4'd9: s = 8'h90;
      default: s = SEG_BLANK;
    endcase
    return s;
  endfunction

  // tens by reciprocal multiply, exact for values up to 99
  function automatic logic [7:0] split_bcd(logic [6:0] v);
    logic [14:0] prod;
    logic [3:0]  tens;
    logic [6:0]  rem;
    prod = {8'd0, v} * 15'd205;
    tens = prod[14:11];
    rem  = v - ({3'd0, tens} * 7'd10);
    return {tens, rem[3:0]};
  endfunction

endpackage

[design/traffic_light_controller.sv]
// Result: the output register holds the result of an input transfer in the next cycle.
// Throughput: one tick per clock; a tick is accepted whenever the output
//   register is empty or its result is being taken in the same cycle.
// Reset: synchronous active-low rst_n puts the phase at NS go, the countdown
//   at 20 s, all counters, display digits and emergency state at zero and the
//   configuration registers at their defaults.
// ----------------------------------------------------------------------------
// Traffic light controller
// Four-phase crossing controller with blinking warn phases, multiplexed
// seconds display and debounced emergency all-red mode.
// ----------------------------------------------------------------------------
`include "traffic_light_controller_assert.svh"

module traffic_light_controller import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_key_pressed,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_ns_lamps,
  output logic [2:0]        out_ew_lamps,
  output logic [1:0]        out_digit_select,
  output logic [7:0]        out_segment_code,
  output logic [1:0]        out_phase,
  output logic              out_emergency_active,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [SEC_W-1:0]   ns_green_r, ew_green_r;
  logic [WARN_W-1:0]  warn_r;
  logic [TICK_W-1:0]  tps_r;
  logic [BLINK_W-1:0] half_r;
  logic [DEB_W-1:0]   deb_r;

  logic       acc, cfg_wr;
  logic [2:0] reg_idx;
  key_view_t  key_view;
  seq_view_t  seq_view;
  logic [1:0] scan_sel;
  logic [7:0] seg;
  logic [2:0] ns_lamps, ew_lamps;

  logic       out_valid_r;
  logic [2:0] out_ns_r, out_ew_r;
  logic [1:0] out_sel_r, out_phase_r;
  logic [7:0] out_seg_r;
  logic       out_emerg_r;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[4:2];
  assign cfg_wr   = psel & penable & pwrite & pready;
  assign in_ready = ~out_valid_r | out_ready;
  assign acc      = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ns_green_r <= RST_NS_GREEN;
      ew_green_r <= RST_EW_GREEN;
      warn_r     <= RST_WARN;
      tps_r      <= RST_TPS;
      half_r     <= RST_BLINK;
      deb_r      <= RST_DEBOUNCE;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_NS_GREEN: ns_green_r <= pwdata[SEC_W-1:0];
        REG_EW_GREEN: ew_green_r <= pwdata[SEC_W-1:0];
        REG_WARN:     warn_r     <= pwdata[WARN_W-1:0];
        REG_TPS:      tps_r      <= pwdata[TICK_W-1:0];
        REG_BLINK:    half_r     <= pwdata[BLINK_W-1:0];
        REG_DEBOUNCE: deb_r      <= pwdata[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_NS_GREEN: prdata = {{(DATA_W-SEC_W){1'b0}}, ns_green_r};
      REG_EW_GREEN: prdata = {{(DATA_W-SEC_W){1'b0}}, ew_green_r};
      REG_WARN:     prdata = {{(DATA_W-WARN_W){1'b0}}, warn_r};
      REG_TPS:      prdata = {{(DATA_W-TICK_W){1'b0}}, tps_r};
      REG_BLINK:    prdata = {{(DATA_W-BLINK_W){1'b0}}, half_r};
      REG_DEBOUNCE: prdata = {{(DATA_W-DEB_W){1'b0}}, deb_r};
      default:      prdata = '0;
    endcase
  end

  tlc_debounce u_debounce (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (acc),
    .key_i       (in_key_pressed),
    .deb_ticks_i (deb_r),
    .view_o      (key_view)
  );

  tlc_sequencer u_sequencer (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_i     (acc),
    .run_i      (~key_view.emergency),
    .ns_green_i (ns_green_r),
    .ew_green_i (ew_green_r),
    .warn_i     (warn_r),
    .tps_i      (tps_r),
    .half_i     (half_r),
    .view_o     (seq_view)
  );

  tlc_display u_display (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (acc),
    .refresh_i (key_view.leave | seq_view.sec_evt),
    .phase_i   (seq_view.phase),
    .seconds_i (seq_view.seconds),
    .warn_i    (warn_r),
    .sel_o     (scan_sel),
    .seg_o     (seg)
  );

  always_comb begin
    if (key_view.emergency) begin
      ns_lamps = LAMP_RED;
      ew_lamps = LAMP_RED;
    end else begin
      case (seq_view.phase)
        PH_NS_GO: begin
          ns_lamps = LAMP_GRN;
          ew_lamps = LAMP_RED;
        end
        PH_NS_WARN: begin
          ns_lamps = seq_view.blink_on ? LAMP_YEL : LAMP_OFF;
          ew_lamps = LAMP_RED;
        end
        PH_EW_GO: begin
          ns_lamps = LAMP_RED;
          ew_lamps = LAMP_GRN;
        end
        default: begin
          ns_lamps = LAMP_RED;
          ew_lamps = seq_view.blink_on ? LAMP_YEL : LAMP_OFF;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (acc) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      out_ns_r    <= ns_lamps;
      out_ew_r    <= ew_lamps;
      out_sel_r   <= scan_sel;
      out_seg_r   <= seg;
      out_phase_r <= seq_view.phase;
      out_emerg_r <= key_view.emergency;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_ns_lamps         = out_ns_r;
  assign out_ew_lamps         = out_ew_r;
  assign out_digit_select     = out_sel_r;
  assign out_segment_code     = out_seg_r;
  assign out_phase            = out_phase_r;
  assign out_emergency_active = out_emerg_r;

  `TLC_ASSERT_NXT(a_result_after_transfer, acc, out_valid_r, "no result after input transfer")
  `TLC_ASSERT_NXT(a_scan_order, acc, out_sel_r == $past(scan_sel), "digit select out of scan order")
  `TLC_ASSERT_IMP(a_emergency_all_red, out_valid_r && out_emerg_r, out_ns_r == LAMP_RED && out_ew_r == LAMP_RED, "emergency result without all red")
  `TLC_ASSERT_IMP(a_frozen_in_emergency, acc && key_view.emergency, !seq_view.sec_evt, "countdown advanced in emergency")
  `TLC_ASSERT_IMP(a_leave_clears, acc && key_view.leave, !key_view.emergency, "leave event while emergency holds")

endmodule

[design/tlc_debounce.sv]
// ----------------------------------------------------------------------------
// Emergency key debounce
// Tracks the key level per tick and enters or leaves emergency mode after
// the level holds for the configured number of ticks.
// ----------------------------------------------------------------------------
module tlc_debounce import tlc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_i,
  input  logic             key_i,
  input  logic [DEB_W-1:0] deb_ticks_i,
  output key_view_t        view_o
);

  logic             emerg_r, emerg_nxt;
  logic             prev_r, prev_nxt;
  logic             pend_r, pend_nxt;
  logic [DEB_W-1:0] cnt_r, cnt_nxt;
  logic             want, arm, pend_a, leave;
  logic [DEB_W-1:0] cnt_a;

  always_comb begin
    want      = ~emerg_r;
    arm       = emerg_r ? ~key_i : (key_i & ~prev_r);
    pend_a    = pend_r | arm;
    cnt_a     = pend_r ? cnt_r : '0;
    pend_nxt  = pend_a;
    cnt_nxt   = cnt_a;
    emerg_nxt = emerg_r;
    leave     = 1'b0;
    prev_nxt  = key_i;
    if (pend_a) begin
      if (key_i != want) begin
        pend_nxt = 1'b0;
        cnt_nxt  = '0;
      end else if (cnt_a >= deb_ticks_i) begin
        pend_nxt  = 1'b0;
        cnt_nxt   = '0;
        emerg_nxt = want;
        leave     = ~want;
      end else begin
        cnt_nxt = cnt_a + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emerg_r <= 1'b0;
      prev_r  <= 1'b0;
      pend_r  <= 1'b0;
      cnt_r   <= '0;
    end else if (step_i) begin
      emerg_r <= emerg_nxt;
      prev_r  <= prev_nxt;
      pend_r  <= pend_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign view_o.emergency = emerg_nxt;
  assign view_o.leave     = leave;

endmodule

[design/tlc_sequencer.sv]
// ----------------------------------------------------------------------------
// Phase sequencer
// Blink and seconds counters, countdown and four-phase rotation.
// ----------------------------------------------------------------------------
module tlc_sequencer import tlc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_i,
  input  logic               run_i,
  input  logic [SEC_W-1:0]   ns_green_i,
  input  logic [SEC_W-1:0]   ew_green_i,
  input  logic [WARN_W-1:0]  warn_i,
  input  logic [TICK_W-1:0]  tps_i,
  input  logic [BLINK_W-1:0] half_i,
  output seq_view_t          view_o
);

  logic [1:0]         phase_r, phase_nxt;
  logic [SEC_W-1:0]   seconds_r, seconds_nxt;
  logic [TICK_W-1:0]  tick_r, tick_nxt;
  logic [BLINK_W-1:0] blink_r, blink_nxt;
  logic               blink_on_r, blink_on_nxt;
  logic               sec_evt;
  logic [BLINK_W:0]   blink_sum;
  logic [TICK_W:0]    tick_sum;
  logic [SEC_W-1:0]   sec_dec;

  always_comb begin
    blink_sum    = {1'b0, blink_r} + 1'b1;
    tick_sum     = {1'b0, tick_r} + 1'b1;
    sec_dec      = (seconds_r != '0) ? seconds_r - 1'b1 : '0;
    phase_nxt    = phase_r;
    seconds_nxt  = seconds_r;
    tick_nxt     = tick_r;
    blink_nxt    = blink_r;
    blink_on_nxt = blink_on_r;
    sec_evt      = 1'b0;
    if (run_i) begin
      if (blink_sum >= {1'b0, half_i}) begin
        blink_nxt    = '0;
        blink_on_nxt = ~blink_on_r;
      end else begin
        blink_nxt = blink_sum[BLINK_W-1:0];
      end
      if (tick_sum >= {1'b0, tps_i}) begin
        tick_nxt = '0;
        sec_evt  = 1'b1;
        if (sec_dec == '0) begin
          phase_nxt = phase_r + 1'b1;
          case (phase_nxt)
            PH_NS_GO: seconds_nxt = ns_green_i;
            PH_EW_GO: seconds_nxt = ew_green_i;
            default:  seconds_nxt = {{(SEC_W-WARN_W){1'b0}}, warn_i};
          endcase
        end else begin
          seconds_nxt = sec_dec;
        end
      end else begin
        tick_nxt = tick_sum[TICK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_NS_GO;
      seconds_r  <= RST_NS_GREEN;
      tick_r     <= '0;
      blink_r    <= '0;
      blink_on_r <= 1'b0;
    end else if (step_i) begin
      phase_r    <= phase_nxt;
      seconds_r  <= seconds_nxt;
      tick_r     <= tick_nxt;
      blink_r    <= blink_nxt;
      blink_on_r <= blink_on_nxt;
    end
  end

  assign view_o.phase    = phase_nxt;
  assign view_o.seconds  = seconds_nxt;
  assign view_o.blink_on = blink_on_nxt;
  assign view_o.sec_evt  = sec_evt;

endmodule

[design/tlc_display.sv]
// ----------------------------------------------------------------------------
// Multiplexed display
// Holds four decimal digits, scans one per tick and refreshes them from the
// countdown on demand.
// ----------------------------------------------------------------------------
module tlc_display import tlc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_i,
  input  logic              refresh_i,
  input  logic [1:0]        phase_i,
  input  logic [SEC_W-1:0]  seconds_i,
  input  logic [WARN_W-1:0] warn_i,
  output logic [1:0]        sel_o,
  output logic [7:0]        seg_o
);

  logic [1:0] scan_r;
  logic [3:0] digits_r [4];
  logic [3:0] digits_nxt [4];
  logic [7:0] sec_ext, sum, ns_val, ew_val;
  logic [6:0] ns_sat, ew_sat;
  logic [7:0] ns_bcd, ew_bcd;

  always_comb begin
    sec_ext = {1'b0, seconds_i};
    sum     = sec_ext + {4'd0, warn_i};
    case (phase_i)
      PH_NS_GO: begin
        ns_val = sec_ext;
        ew_val = sum;
      end
      PH_EW_GO: begin
        ns_val = sum;
        ew_val = sec_ext;
      end
      default: begin
        ns_val = sec_ext;
        ew_val = sec_ext;
      end
    endcase
    ns_sat = (ns_val > {1'b0, SHOW_MAX}) ? SHOW_MAX : ns_val[6:0];
    ew_sat = (ew_val > {1'b0, SHOW_MAX}) ? SHOW_MAX : ew_val[6:0];
    ns_bcd = split_bcd(ns_sat);
    ew_bcd = split_bcd(ew_sat);
    digits_nxt[0] = ew_bcd[7:4];
    digits_nxt[1] = ew_bcd[3:0];
    digits_nxt[2] = ns_bcd[7:4];
    digits_nxt[3] = ns_bcd[3:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= '0;
      for (int i = 0; i < 4; i++) begin
        digits_r[i] <= '0;
      end
    end else if (step_i) begin
      scan_r <= scan_r + 1'b1;
      if (refresh_i) begin
        for (int i = 0; i < 4; i++) begin
          digits_r[i] <= digits_nxt[i];
        end
      end
    end
  end

  assign sel_o = scan_r;
  assign seg_o = seg_lookup(digits_r[scan_r]);

endmodule

[sim/tb_traffic_light_controller.sv]
// ----------------------------------------------------------------------------
// Traffic light controller testbench
// Sends emergency key ticks through the valid/ready input and programs the
// timing registers over the APB port between phases. A cycle-true software
// copy of the controller predicts each result tick, and every field of every
// transfer on the result channel is compared against it. Both sides idle at
// random, and the receiver holds off once to fill the block.
// ----------------------------------------------------------------------------
module tb_traffic_light_controller import tlc_pkg::*;;

  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    logic [2:0] ns_lamps;
    logic [2:0] ew_lamps;
    logic [1:0] digit_select;
    logic [7:0] segment_code;
    logic [1:0] phase;
    logic       emergency_active;
  } tick_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_key_pressed = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [2:0]        out_ns_lamps;
  logic [2:0]        out_ew_lamps;
  logic [1:0]        out_digit_select;
  logic [7:0]        out_segment_code;
  logic [1:0]        out_phase;
  logic              out_emergency_active;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // timing configuration mirrored from register writes
  logic [SEC_W-1:0]   cfg_ns_green = RST_NS_GREEN;
  logic [SEC_W-1:0]   cfg_ew_green = RST_EW_GREEN;
  logic [WARN_W-1:0]  cfg_warn     = RST_WARN;
  logic [TICK_W-1:0]  cfg_tps      = RST_TPS;
  logic [BLINK_W-1:0] cfg_blink    = RST_BLINK;
  logic [DEB_W-1:0]   cfg_debounce = RST_DEBOUNCE;

  // controller state
  logic [1:0]         phase_q      = PH_NS_GO;
  logic [SEC_W-1:0]   secs_left    = RST_NS_GREEN;
  logic [TICK_W-1:0]  tick_cnt     = '0;
  logic [BLINK_W-1:0] blink_cnt    = '0;
  logic               blink_lit    = 1'b0;
  logic [1:0]         scan_pos     = 2'd0;
  logic [3:0]         shown [4]    = '{default: 4'd0};
  logic               emergency_on = 1'b0;
  logic               key_prev     = 1'b0;
  logic               deb_pending  = 1'b0;
  logic [DEB_W-1:0]   deb_cnt      = '0;

  tick_result_t expected_ticks [$];
  int           mismatch_count = 0;
  int           cycle_count = 0;
  bit           sender_gaps = 1'b1;
  logic         ready_gaps = 1'b1;
  logic         hold_start = 1'b0;
  logic         hold_seen = 1'b0;
  int           hold_left = 0;

  traffic_light_controller uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_key_pressed       (in_key_pressed),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_ns_lamps         (out_ns_lamps),
    .out_ew_lamps         (out_ew_lamps),
    .out_digit_select     (out_digit_select),
    .out_segment_code     (out_segment_code),
    .out_phase            (out_phase),
    .out_emergency_active (out_emergency_active),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic void refresh_shown();
    int ns_val;
    int ew_val;
    ns_val = int'(secs_left);
    ew_val = int'(secs_left);
    if (phase_q == PH_NS_GO) ew_val = int'(secs_left) + int'(cfg_warn);
    else if (phase_q == PH_EW_GO) ns_val = int'(secs_left) + int'(cfg_warn);
    if (ns_val > int'(SHOW_MAX)) ns_val = int'(SHOW_MAX);
    if (ew_val > int'(SHOW_MAX)) ew_val = int'(SHOW_MAX);
    shown[0] = 4'(ew_val / 10);
    shown[1] = 4'(ew_val % 10);
    shown[2] = 4'(ns_val / 10);
    shown[3] = 4'(ns_val % 10);
  endfunction

  function automatic tick_result_t step_tick(logic key);
    tick_result_t r;
    logic [3:0]   digit;
    logic         want;
    logic         arm;
    r.digit_select = scan_pos;
    digit = shown[scan_pos];
    case (digit)
      4'd0:    r.segment_code = 8'hC0;
      4'd1:    r.segment_code = 8'hF9;
      4'd2:    r.segment_code = 8'hA4;
      4'd3:    r.segment_code = 8'hB0;
      4'd4:    r.segment_code = 8'h99;
      4'd5:    r.segment_code = 8'h92;
      4'd6:    r.segment_code = 8'h82;
      4'd7:    r.segment_code = 8'hF8;
      4'd8:    r.segment_code = 8'h80;
      4'd9:    r.segment_code = 8'h90;
      default: r.segment_code = SEG_BLANK;
    endcase
    scan_pos = scan_pos + 2'd1;

    // debounce the emergency key
    want = !emergency_on;
    if (!deb_pending) begin
      arm = emergency_on ? !key : (key && !key_prev);
      if (arm) begin
        deb_pending = 1'b1;
        deb_cnt = '0;
      end
    end
    if (deb_pending) begin
      if (key != want) begin
        deb_pending = 1'b0;
        deb_cnt = '0;
      end else if (deb_cnt >= cfg_debounce) begin
        deb_pending = 1'b0;
        deb_cnt = '0;
        emergency_on = want;
        if (!emergency_on) refresh_shown();
      end else begin
        deb_cnt = deb_cnt + 1'b1;
      end
    end
    key_prev = key;

    if (!emergency_on) begin
      blink_cnt = blink_cnt + 1'b1;
      if (blink_cnt >= cfg_blink) begin
        blink_cnt = '0;
        blink_lit = !blink_lit;
      end
      tick_cnt = tick_cnt + 1'b1;
      if (tick_cnt >= cfg_tps) begin
        tick_cnt = '0;
        if (secs_left != 0) secs_left = secs_left - 1'b1;
        if (secs_left == 0) begin
          phase_q = phase_q + 2'd1;
          case (phase_q)
            PH_NS_GO: secs_left = cfg_ns_green;
            PH_EW_GO: secs_left = cfg_ew_green;
            default:  secs_left = {3'd0, cfg_warn};
          endcase
        end
        refresh_shown();
      end
      case (phase_q)
        PH_NS_GO: begin
          r.ns_lamps = LAMP_GRN;
          r.ew_lamps = LAMP_RED;
        end
        PH_NS_WARN: begin
          r.ns_lamps = blink_lit ? LAMP_YEL : LAMP_OFF;
          r.ew_lamps = LAMP_RED;
        end
        PH_EW_GO: begin
          r.ns_lamps = LAMP_RED;
          r.ew_lamps = LAMP_GRN;
        end
        default: begin
          r.ns_lamps = LAMP_RED;
          r.ew_lamps = blink_lit ? LAMP_YEL : LAMP_OFF;
        end
      endcase
    end else begin
      r.ns_lamps = LAMP_RED;
      r.ew_lamps = LAMP_RED;
    end
    r.phase = phase_q;
    r.emergency_active = emergency_on;
    return r;
  endfunction

  task automatic note_mismatch(input string what, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    if (mismatch_count < MAX_REPORTS)
      $display("mismatch %s: expected %0h, got %0h", what, exp_v, act_v);
    mismatch_count++;
  endtask

  // retire the result transfer first, then predict the tick taken at this edge
  always @(posedge clk) begin : result_check
    tick_result_t got;
    tick_result_t predicted;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got = {out_ns_lamps, out_ew_lamps, out_digit_select, out_segment_code,
               out_phase, out_emergency_active};
        if (expected_ticks.size() == 0) begin
          note_mismatch("result with none pending", 32'd0, 32'(got));
        end else begin
          predicted = expected_ticks.pop_front();
          if (got.ns_lamps !== predicted.ns_lamps)
            note_mismatch("ns_lamps", 32'(predicted.ns_lamps), 32'(got.ns_lamps));
          if (got.ew_lamps !== predicted.ew_lamps)
            note_mismatch("ew_lamps", 32'(predicted.ew_lamps), 32'(got.ew_lamps));
          if (got.digit_select !== predicted.digit_select)
            note_mismatch("digit_select", 32'(predicted.digit_select),
                          32'(got.digit_select));
          if (got.segment_code !== predicted.segment_code)
            note_mismatch("segment_code", 32'(predicted.segment_code),
                          32'(got.segment_code));
          if (got.phase !== predicted.phase)
            note_mismatch("phase", 32'(predicted.phase), 32'(got.phase));
          if (got.emergency_active !== predicted.emergency_active)
            note_mismatch("emergency_active", 32'(predicted.emergency_active),
                          32'(got.emergency_active));
        end
      end
      if (in_valid && in_ready) expected_ticks.push_back(step_tick(in_key_pressed));
    end
  end

  always @(posedge clk) begin
    if (hold_start != hold_seen) begin
      hold_seen <= hold_start;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !ready_gaps || ($urandom_range(99) >= 10);
    end
  end

  task automatic send_tick(input logic key);
    while (sender_gaps && $urandom_range(99) < 10) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_pressed <= key;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_run(input logic key, input int len);
    repeat (len) send_tick(key);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_ticks.size() != 0) @(posedge clk);
  endtask

  task automatic read_register(input logic [2:0] idx, output logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= ADDR_W'({idx, 2'b00});
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] mask;
    logic [DATA_W-1:0] readback;
    mask = '0;
    case (idx)
      REG_NS_GREEN: begin
        mask = (1 << SEC_W) - 1;
        cfg_ns_green = value[SEC_W-1:0];
      end
      REG_EW_GREEN: begin
        mask = (1 << SEC_W) - 1;
        cfg_ew_green = value[SEC_W-1:0];
      end
      REG_WARN: begin
        mask = (1 << WARN_W) - 1;
        cfg_warn = value[WARN_W-1:0];
      end
      REG_TPS: begin
        mask = (1 << TICK_W) - 1;
        cfg_tps = value[TICK_W-1:0];
      end
      REG_BLINK: begin
        mask = (1 << BLINK_W) - 1;
        cfg_blink = value[BLINK_W-1:0];
      end
      default: begin
        mask = (1 << DEB_W) - 1;
        cfg_debounce = value[DEB_W-1:0];
      end
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    read_register(idx, readback);
    if (readback !== (value & mask)) note_mismatch("register readback", value & mask, readback);
  endtask

  task automatic configure(input int ns, input int ew, input int warn, input int tps,
                           input int blink, input int deb);
    wait_idle();
    write_register(REG_NS_GREEN, ns);
    write_register(REG_EW_GREEN, ew);
    write_register(REG_WARN, warn);
    write_register(REG_TPS, tps);
    write_register(REG_BLINK, blink);
    write_register(REG_DEBOUNCE, deb);
  endtask

  function automatic int pick_biased(input int near_max, input int full_max);
    return ($urandom_range(3) != 0) ? $urandom_range(0, near_max)
                                    : $urandom_range(0, full_max);
  endfunction

  // mostly clean press/release pairs, mixed at random with quiet stretches and key chatter
  task automatic drive_key_traffic(input int count);
    int sent;
    int len;
    int kind;
    sent = 0;
    while (sent < count) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        len = cfg_debounce + 1 + $urandom_range(0, 4);
        send_run(1'b1, len);
        sent += len;
        len = cfg_debounce + 1 + $urandom_range(0, 6);
        send_run(1'b0, len);
        sent += len;
      end else if (kind < 80) begin
        len = $urandom_range(1, 10);
        send_run(1'b0, len);
        sent += len;
      end else begin
        len = $urandom_range(1, 6);
        repeat (len) send_tick(1'($urandom_range(1)));
        sent += len;
      end
    end
  endtask

  task automatic test_register_defaults();
    logic [DATA_W-1:0] dflt [6];
    logic [DATA_W-1:0] v;
    dflt = '{DATA_W'(RST_NS_GREEN), DATA_W'(RST_EW_GREEN), DATA_W'(RST_WARN),
             DATA_W'(RST_TPS), DATA_W'(RST_BLINK), DATA_W'(RST_DEBOUNCE)};
    for (int i = 0; i < 6; i++) begin
      read_register(i[2:0], v);
      if (v !== dflt[i]) note_mismatch("register default", dflt[i], v);
    end
  endtask

  task automatic test_phase_rotation();
    configure(1, 1, 1, 1, 1, 0);
    send_run(1'b0, 22);
  endtask

  task automatic test_emergency_immediate();
    send_run(1'b1, 2);
    send_run(1'b0, 2);
  endtask

  task automatic test_display_saturation();
    configure(127, 0, 15, 0, 0, 15);
    send_run(1'b0, 1);
    send_run(1'b1, 2);
    send_run(1'b0, 3);
  endtask

  task automatic test_slow_extremes();
    configure(90, 90, 9, 1023, 511, 15);
    drive_key_traffic(60);
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 8; p++) begin
      configure(pick_biased(6, 127), pick_biased(6, 127), $urandom_range(0, 15),
                pick_biased(4, 1023), pick_biased(6, 511), pick_biased(3, 15));
      sender_gaps = (p != 3);
      ready_gaps <= (p != 3);
      drive_key_traffic(80);
    end
    sender_gaps = 1'b1;
    ready_gaps <= 1'b1;
  endtask

  task automatic test_output_backpressure();
    configure(3, 2, 1, 2, 1, 1);
    hold_start <= ~hold_start;
    drive_key_traffic(40);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_register_defaults();
    test_phase_rotation();
    test_emergency_immediate();
    test_display_saturation();
    test_slow_extremes();
    test_random_traffic();
    test_output_backpressure();
    wait_idle();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
